@@ hdl/cmg_pkg.sv @@
// Package for the calendar month grid generator: field widths, year limits,
// action codes, the microcode control word and the month tables.
// Depends on nothing; every other file of the block imports it.
package cmg_pkg;

  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned COL_W    = 3;
  localparam int unsigned ROW_W    = 3;
  localparam int unsigned CLASS_W  = 2;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned PC_W     = 3;
  localparam int unsigned Q100_W   = 5;
  localparam int unsigned SUM_W    = 13;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [YEAR_W-1:0]  MIN_YEAR   = 12'd1001;
  localparam logic [YEAR_W-1:0]  MAX_YEAR   = 12'd2999;
  localparam logic [YEAR_W-1:0]  RESET_YEAR = 12'd2000;
  localparam logic [MONTH_W-1:0] JANUARY    = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER   = 4'd12;
  localparam logic [COL_W-1:0]   SUNDAY     = 3'd0;
  localparam logic [COL_W-1:0]   SATURDAY   = 3'd6;

  // Floor division by 100 as a multiply by 1311 and a shift of 17 places,
  // exact for every year below 4096.
  localparam int unsigned RECIP_W    = 11;
  localparam logic [RECIP_W-1:0] RECIP_100 = 11'd1311;
  localparam int unsigned RECIP_SH   = 17;
  localparam int unsigned PROD_W     = YEAR_W + RECIP_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SHOW       = 3'd0,
    ACT_MONTH_UP   = 3'd1,
    ACT_MONTH_DOWN = 3'd2,
    ACT_YEAR_UP    = 3'd3,
    ACT_YEAR_DOWN  = 3'd4,
    ACT_SET        = 3'd5
  } action_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_ORDINARY = 2'd0,
    CLS_SUNDAY   = 2'd1,
    CLS_SATURDAY = 2'd2
  } day_class_t;

  typedef enum logic [1:0] {
    COND_ALWAYS    = 2'd0,
    COND_IN_BEAT   = 2'd1,
    COND_LAST_BEAT = 2'd2
  } cond_t;

  typedef enum logic {
    MUL_PREV = 1'b0,
    MUL_YEAR = 1'b1
  } mul_sel_t;

  localparam logic [PC_W-1:0] STEP_WAIT  = 3'd0;
  localparam logic [PC_W-1:0] STEP_MULP  = 3'd1;
  localparam logic [PC_W-1:0] STEP_MULY  = 3'd2;
  localparam logic [PC_W-1:0] STEP_FIRST = 3'd3;
  localparam logic [PC_W-1:0] STEP_EMIT  = 3'd4;

  typedef struct packed {
    logic             wait_in;
    logic             mul_en;
    mul_sel_t         mul_sel;
    logic             ld_qprev;
    logic             ld_first;
    logic             emit;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  typedef struct packed {
    logic in_beat;
    logic last_beat;
  } status_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    cw = '0;
    cw.cond   = COND_ALWAYS;
    cw.target = STEP_WAIT;
    case (pc)
      STEP_WAIT: begin
        cw.wait_in = 1'b1;
        cw.cond    = COND_IN_BEAT;
        cw.target  = STEP_MULP;
      end
      STEP_MULP: begin
        cw.mul_en  = 1'b1;
        cw.mul_sel = MUL_PREV;
        cw.target  = STEP_MULY;
      end
      STEP_MULY: begin
        cw.ld_qprev = 1'b1;
        cw.mul_en   = 1'b1;
        cw.mul_sel  = MUL_YEAR;
        cw.target   = STEP_FIRST;
      end
      STEP_FIRST: begin
        cw.ld_first = 1'b1;
        cw.target   = STEP_EMIT;
      end
      STEP_EMIT: begin
        cw.emit   = 1'b1;
        cw.cond   = COND_LAST_BEAT;
        cw.target = STEP_WAIT;
      end
      default: begin
        cw.target = STEP_WAIT;
      end
    endcase
    return cw;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
      4'd2:                                      n = 5'd28;
      default:                                   n = 5'd0;
    endcase
    return n;
  endfunction

  // Days before the first of each month in a common year.
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  localparam int unsigned HOL_N = 11;
  localparam logic [HOL_N-1:0][MONTH_W-1:0] HOL_MONTH = {
    4'd12, 4'd10, 4'd10, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd1, 4'd1
  };
  localparam logic [HOL_N-1:0][DAY_W-1:0] HOL_DAY = {
    5'd25, 5'd3, 5'd1, 5'd15, 5'd17, 5'd6, 5'd5, 5'd5, 5'd1, 5'd2, 5'd1
  };

  function automatic logic holiday_hit(input logic [MONTH_W-1:0] m,
                                       input logic [DAY_W-1:0] d);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < HOL_N; k++) begin
      if (m == HOL_MONTH[k] && d == HOL_DAY[k]) hit = 1'b1;
    end
    return hit;
  endfunction

  // Remainder by seven through sums of octal digits, since eight leaves one.
  function automatic logic [COL_W-1:0] mod7(input logic [SUM_W-1:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    logic [3:0] r;
    s1 = {2'b0, x[2:0]} + {2'b0, x[5:3]} + {2'b0, x[8:6]} + {2'b0, x[11:9]}
       + {4'b0, x[12]};
    s2 = {1'b0, s1[2:0]} + {2'b0, s1[4:3]};
    r  = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
    return r[COL_W-1:0];
  endfunction

endpackage

@@ hdl/cmg_sequencer.sv @@
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on cmg_pkg for the control word, status and control store.
module cmg_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  cmg_pkg::status_t st,
  output cmg_pkg::ctrl_t   cw
);
  import cmg_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            cond_met;

  assign cw = ucode(pc_r);

  always_comb begin
    case (cw.cond)
      COND_ALWAYS:    cond_met = 1'b1;
      COND_IN_BEAT:   cond_met = st.in_beat;
      COND_LAST_BEAT: cond_met = st.last_beat;
      default:        cond_met = 1'b1;
    endcase
    pc_nxt = cond_met ? cw.target : pc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ hdl/cmg_datapath.sv @@
// Datapath: year and month registers, navigation, shared multiplier, weekday
// of the first, day counters and the output register.
// Depends on cmg_pkg; driven by the control word from cmg_sequencer.
module cmg_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmg_pkg::ctrl_t                cw,
  output cmg_pkg::status_t              st,
  input  logic                          cfg_wr_en,
  input  logic [cmg_pkg::DAY_W-1:0]     cfg_wr_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cmg_pkg::ACTION_W-1:0]  in_tuser,
  input  logic [cmg_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cmg_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast
);
  import cmg_pkg::*;

  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [DAY_W-1:0]   today_r;
  logic [PROD_W-1:0]  prod_r;
  logic [Q100_W-1:0]  qprev_r;
  logic [DAY_W-1:0]   day_r, ndays_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic               out_last_r;

  logic               in_beat, emit_beat;
  logic [YEAR_W-1:0]  set_y, set_year_c, year_inc, year_dec, prev;
  logic [MONTH_W-1:0] set_m, set_month_c;
  logic [YEAR_W-1:0]  mul_a;
  logic [Q100_W-1:0]  qy;
  logic [YEAR_W-1:0]  qy_x100;
  logic               leap;
  logic [SUM_W-1:0]   tot;
  logic [DAY_W-1:0]   ndays_c;
  logic               hol;
  day_class_t         cls;
  logic               last_day;

  assign set_y = in_tdata[YEAR_W-1:0];
  assign set_m = in_tdata[YEAR_W+MONTH_W-1:YEAR_W];

  assign in_tready = cw.wait_in;
  assign in_beat   = in_tvalid && cw.wait_in;
  assign emit_beat = cw.emit && (!out_valid_r || out_tready);
  assign last_day  = (day_r == ndays_r);
  assign st.in_beat   = in_beat;
  assign st.last_beat = emit_beat && last_day;

  assign year_inc = year_r + 12'd1;
  assign year_dec = year_r - 12'd1;
  assign prev     = year_r - 12'd1;

  always_comb begin
    set_year_c = set_y;
    if (set_year_c > MAX_YEAR) set_year_c = MAX_YEAR;
    if (set_year_c < MIN_YEAR) set_year_c = MIN_YEAR;
    set_month_c = set_m;
    if (set_month_c < JANUARY)  set_month_c = JANUARY;
    if (set_month_c > DECEMBER) set_month_c = DECEMBER;

    year_nxt  = year_r;
    month_nxt = month_r;
    case (action_t'(in_tuser))
      ACT_MONTH_UP: begin
        if (month_r >= DECEMBER) begin
          if (year_r >= MAX_YEAR) begin
            month_nxt = DECEMBER;
          end else begin
            year_nxt  = year_inc;
            month_nxt = JANUARY;
          end
        end else begin
          month_nxt = month_r + 4'd1;
        end
      end
      ACT_MONTH_DOWN: begin
        if (month_r <= JANUARY) begin
          if (year_r <= MIN_YEAR) begin
            month_nxt = JANUARY;
          end else begin
            year_nxt  = year_dec;
            month_nxt = DECEMBER;
          end
        end else begin
          month_nxt = month_r - 4'd1;
        end
      end
      ACT_YEAR_UP: begin
        year_nxt = (year_inc > MAX_YEAR) ? MAX_YEAR : year_inc;
      end
      ACT_YEAR_DOWN: begin
        year_nxt = (year_dec < MIN_YEAR) ? MIN_YEAR : year_dec;
      end
      ACT_SET: begin
        year_nxt  = set_year_c;
        month_nxt = set_month_c;
      end
      default: begin
        year_nxt  = year_r;
        month_nxt = month_r;
      end
    endcase
  end

  assign mul_a = (cw.mul_sel == MUL_YEAR) ? year_r : prev;

  assign qy      = prod_r[RECIP_SH+Q100_W-1:RECIP_SH];
  assign qy_x100 = YEAR_W'(qy * 7'd100);
  assign leap    = (year_r[1:0] == 2'b00) && ((year_r != qy_x100) || (qy[1:0] == 2'b00));

  always_comb begin
    tot = {1'b0, prev} + {3'b0, prev[YEAR_W-1:2]} - {{(SUM_W-Q100_W){1'b0}}, qprev_r}
        + {{(SUM_W-Q100_W+2){1'b0}}, qprev_r[Q100_W-1:2]}
        + {4'b0, month_offset(month_r)}
        + {{(SUM_W-1){1'b0}}, (leap && month_r > FEBRUARY)}
        + 13'd1;
    ndays_c = month_len(month_r) + {{(DAY_W-1){1'b0}}, (leap && month_r == FEBRUARY)};
  end

  assign hol = holiday_hit(month_r, day_r);
  always_comb begin
    if (hol || col_r == SUNDAY) begin
      cls = CLS_SUNDAY;
    end else if (col_r == SATURDAY) begin
      cls = CLS_SATURDAY;
    end else begin
      cls = CLS_ORDINARY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r      <= RESET_YEAR;
      month_r     <= JANUARY;
      today_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) today_r <= cfg_wr_data;
      if (in_beat) begin
        year_r  <= year_nxt;
        month_r <= month_nxt;
      end
      if (emit_beat) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw.mul_en) prod_r <= PROD_W'(mul_a * RECIP_100);
    if (cw.ld_qprev) qprev_r <= qy;
    if (cw.ld_first) begin
      col_r   <= mod7(tot);
      row_r   <= '0;
      day_r   <= 5'd1;
      ndays_r <= ndays_c;
    end else if (emit_beat) begin
      day_r <= day_r + 5'd1;
      if (col_r == SATURDAY) begin
        col_r <= SUNDAY;
        row_r <= row_r + 3'd1;
      end else begin
        col_r <= col_r + 3'd1;
      end
    end
    if (emit_beat) begin
      out_data_r <= {1'b0, (day_r == today_r), cls, hol, row_r, col_r, day_r,
                     month_r, year_r};
      out_last_r <= last_day;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ hdl/calendar_month_grid_generator.sv @@
// Order of work: the wait step takes an input beat, the multiply steps and the first-day
// step follow, then the single emit step sends one day per cycle unless the output stalls.
// A new navigation beat is taken only after the month's last day cell has been sent.
// Reset: synchronous, active low; year 2000, January, no day marked as today.
// Top level of the month grid generator; instantiates cmg_sequencer and cmg_datapath.
module calendar_month_grid_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [cmg_pkg::DAY_W-1:0]      cfg_wr_data,   // today_day
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cmg_pkg::ACTION_W-1:0]   in_tuser,      // action
  input  logic [cmg_pkg::IN_DATA_W-1:0]  in_tdata,      // set_year, set_month
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // shown_year, shown_month, day_number, grid_column, grid_row, holiday_flag,
  // day_class, today_flag, one zero bit
  output logic [cmg_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast      // last_cell
);
  import cmg_pkg::*;

  ctrl_t   cw;
  status_t st;

  cmg_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cw    (cw)
  );

  cmg_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cw          (cw),
    .st          (st),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

`ifndef SYNTH
  a_cells_run_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("day cells of a month are not sent back to back");

  a_day_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tdata[20:16] == $past(out_tdata[20:16]) + 5'd1)
    else $error("day number does not advance by one");

  a_grid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[20:16] != 5'd0 && out_tdata[23:21] <= 3'd6
                   && out_tdata[26:24] <= 3'd5)
    else $error("cell outside the month grid");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a month is being laid out");
`endif

endmodule
